[rtl/dna_rule_pixel_cipher_pass_core_assert.svh]
// assertion macros for the dna rule pixel cipher core
`ifndef DNA_RULE_PIXEL_CIPHER_PASS_CORE_ASSERT_SVH
`define DNA_RULE_PIXEL_CIPHER_PASS_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DRPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("drpc assertion failed");

// next-cycle implication, disabled while reset is low
`define DRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("drpc assertion failed");

`endif

[rtl/drpc_pkg.sv]
// shared types, constants and rule tables for the dna rule pixel cipher
package drpc_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned PairW  = 2;
  localparam int unsigned RuleW  = 3;
  localparam int unsigned NPairs = PixW / PairW;
  localparam int unsigned NRules = 1 << RuleW;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [PairW-1:0] pair_t;
  typedef logic [RuleW-1:0] rule_t;
  typedef rule_t [NPairs-1:0] rule_vec_t;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_e;

  // pair to base under each rule (A=0, C=1, G=2, T=3)
  localparam pair_t RULE_TAB [NRules][NPairs] = '{
    '{2'd2, 2'd0, 2'd3, 2'd1},
    '{2'd3, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd3, 2'd0, 2'd2},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // base back to pair under each rule
  localparam pair_t INV_TAB [NRules][NPairs] = '{
    '{2'd1, 2'd3, 2'd0, 2'd2},
    '{2'd3, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd2, 2'd0, 2'd3, 2'd1},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

endpackage

[rtl/drpc_if.sv]
// valid/ready channel interfaces for pixel beats in and out
interface drpc_in_if;
  import drpc_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  logic  first_of_pass;
  pix_t  pixel_in;
  rule_t x_rule_0;
  rule_t x_rule_1;
  rule_t x_rule_2;
  rule_t x_rule_3;
  rule_t y_rule_0;
  rule_t y_rule_1;
  rule_t y_rule_2;
  rule_t y_rule_3;
  rule_t z_code;

  modport source (
    output valid, mode, first_of_pass, pixel_in,
           x_rule_0, x_rule_1, x_rule_2, x_rule_3,
           y_rule_0, y_rule_1, y_rule_2, y_rule_3, z_code,
    input  ready
  );

  modport sink (
    input  valid, mode, first_of_pass, pixel_in,
           x_rule_0, x_rule_1, x_rule_2, x_rule_3,
           y_rule_0, y_rule_1, y_rule_2, y_rule_3, z_code,
    output ready
  );
endinterface

interface drpc_out_if;
  import drpc_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

[rtl/drpc_xform.sv]
// per-pair dna code and decode of one byte, four lanes side by side
module drpc_xform (
  input  drpc_pkg::pix_t      byte_i,
  input  drpc_pkg::rule_vec_t enc_rules_i,
  input  drpc_pkg::rule_vec_t dec_rules_i,
  output drpc_pkg::pix_t      byte_o
);
  import drpc_pkg::*;

  // lane i handles the pair at the top end first
  for (genvar i = 0; i < NPairs; i++) begin : g_lane
    localparam int unsigned Lo = PixW - PairW * (i + 1);
    pair_t pair_in;
    pair_t base;

    assign pair_in = byte_i[Lo +: PairW];
    assign base    = RULE_TAB[enc_rules_i[i]][pair_in];
    assign byte_o[Lo +: PairW] = INV_TAB[dec_rules_i[i]][base];
  end

endmodule

[rtl/dna_rule_pixel_cipher_pass_core.sv]
// top level of the dna rule pixel cipher, one pixel beat per cycle while the output is not stalled
//
//  channel  dir  handshake        payload
//  in_i     in   valid / ready    mode, first_of_pass, pixel_in, x/y rules, z_code
//  out_o    out  valid / ready    pixel_out
//
// one beat per cycle sustained while out_o is ready; the result is registered and appears in the cycle after acceptance
// the only loop is the 8-bit feedback mask, updated at each accepted beat
// reset clears the result valid flag and the feedback mask
// a stalled output holds its result; input is still taken if the result
// register empties in the same cycle
module dna_rule_pixel_cipher_pass_core (
  input  logic clk_i,
  input  logic rst_ni,
  drpc_in_if.sink    in_i,
  drpc_out_if.source out_o
);
  import drpc_pkg::*;

  `include "dna_rule_pixel_cipher_pass_core_assert.svh"

  logic      out_valid_q, out_valid_d;
  pix_t      pix_out_q, pix_out_d;
  pix_t      mask_q, mask_d;
  logic      in_acc;
  logic      is_dec;
  pix_t      mask_eff;
  pix_t      zval;
  pix_t      xf_in, xf_out;
  rule_vec_t x_rules, y_rules, enc_rules, dec_rules;

  // handshake: the result register frees up when its beat is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // gather rule fields, pair 0 first
  assign x_rules = {in_i.x_rule_3, in_i.x_rule_2, in_i.x_rule_1, in_i.x_rule_0};
  assign y_rules = {in_i.y_rule_3, in_i.y_rule_2, in_i.y_rule_1, in_i.y_rule_0};

  // mode select and diffusion terms
  assign is_dec    = (in_i.mode == MODE_DEC);
  assign mask_eff  = in_i.first_of_pass ? '0 : mask_q;
  assign zval      = PixW'(in_i.z_code) + PixW'(1);
  assign enc_rules = is_dec ? y_rules : x_rules;
  assign dec_rules = is_dec ? x_rules : y_rules;
  assign xf_in     = is_dec ? (in_i.pixel_in ^ zval ^ mask_eff) : in_i.pixel_in;

  drpc_xform u_xform (
    .byte_i      (xf_in),
    .enc_rules_i (enc_rules),
    .dec_rules_i (dec_rules),
    .byte_o      (xf_out)
  );

  // result and next mask
  always_comb begin
    pix_out_d   = pix_out_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      out_valid_d = 1'b1;
      if (is_dec) begin
        pix_out_d = xf_out;
        mask_d    = in_i.pixel_in;
      end else begin
        pix_out_d = xf_out ^ zval ^ mask_eff;
        mask_d    = xf_out ^ zval ^ mask_eff;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mask_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pix_out_q <= pix_out_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = pix_out_q;

  // checks
  `DRPC_ASSERT_NEXT(a_enc_mask_is_result, clk_i, rst_ni, in_acc && !is_dec, mask_q == pix_out_q)
  `DRPC_ASSERT_NEXT(a_dec_mask_is_input, clk_i, rst_ni, in_acc && is_dec, mask_q == $past(in_i.pixel_in))
  `DRPC_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_acc, out_valid_q)
  `DRPC_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, in_i.ready)

endmodule
